>>> design/ssnf_pkg.sv
// Shared types and constants for the seven-segment number formatter.
package ssnf_pkg;

   localparam int DIGIT_COUNT = 6;
   localparam int BIN_WIDTH   = 20;
   localparam int BCD_WIDTH   = 4 * DIGIT_COUNT;
   localparam int CNT_WIDTH   = $clog2(BIN_WIDTH);

   localparam logic [17:0]        MAP_RESET       = 18'd181896;
   localparam logic signed [31:0] INT_UPPER_RESET = 32'sd999999;
   localparam logic signed [31:0] INT_LOWER_RESET = -32'sd99999;
   localparam logic [31:0]        HEX_UPPER_RESET = 32'h00FF_FFFF;
   localparam logic [31:0]        HEX_LOWER_RESET = 32'h0000_0000;

   localparam logic signed [31:0] INT_MAX_SHOWN = 32'sd999999;
   localparam logic signed [31:0] INT_MIN_SHOWN = -32'sd99999;

   typedef enum logic [1:0] {
      OP_WRITE_INT,
      OP_WRITE_HEX,
      OP_INCREMENT,
      OP_DECREMENT
   } opcode_type;

   typedef enum logic [1:0] {
      CMD_CLEAR,
      CMD_DIGIT,
      CMD_MINUS
   } command_type;

   typedef enum logic [1:0] {
      MODE_NONE,
      MODE_INT,
      MODE_HEX
   } mode_type;

   typedef enum logic [2:0] {
      CSR_DIGIT_MAP,
      CSR_INT_UPPER,
      CSR_INT_LOWER,
      CSR_HEX_UPPER,
      CSR_HEX_LOWER
   } csr_index_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_STEP,
      S_CHECK,
      S_INT_PREP,
      S_CONV,
      S_CLEAR,
      S_DIGIT,
      S_MINUS
   } state_type;

   typedef struct packed {
      logic                 start;
      logic [BIN_WIDTH-1:0] value;
   } dabble_req_type;

   typedef struct packed {
      logic                 done;
      logic [BCD_WIDTH-1:0] bcd;
   } dabble_rsp_type;

endpackage

>>> design/seven_segment_number_formatter.sv
// Top level of the seven-segment number formatter.
// One request is taken at a time; req_ready is high only while the block is idle.
// A write-hex request yields its seven results (clear and six nibbles) one per cycle
// while rsp_ready is held high. A write-integer request first runs sign and range
// checks, then passes through the bit-serial binary-to-decimal converter (one bit of
// a 20-bit magnitude per cycle), then delivers two to seven results at one per cycle
// while rsp_ready is held high; an out-of-range value skips the converter and gives
// only the clear. Increment and decrement first do the 33-bit add, then the limit
// compare, before rendering, and a refused step or a step with nothing shown gives
// no result.
module seven_segment_number_formatter (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_opcode,
   input  logic signed [31:0] req_operand,
   input  logic [7:0]         req_point_mask,
   input  logic               req_align_right,
   input  logic               req_zero_fill,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_command_kind,
   output logic [2:0]         rsp_digit_position,
   output logic [3:0]         rsp_digit_value,
   output logic               rsp_point_on,
   output logic               rsp_last_command,
   input  logic               csr_write_enable,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_write_data
);
   import ssnf_pkg::*;

   state_type            state_ff, state_in;
   logic [17:0]          map_ff;
   logic [31:0]          int_upper_ff, int_lower_ff, hex_upper_ff, hex_lower_ff;
   logic [31:0]          stored_int_ff, stored_int_in;
   logic [31:0]          stored_hex_ff, stored_hex_in;
   logic [7:0]           stored_point_ff, stored_point_in;
   logic                 stored_align_ff, stored_align_in;
   logic                 stored_fill_ff, stored_fill_in;
   mode_type             mode_ff, mode_in;
   opcode_type           op_ff, op_in;
   logic [31:0]          operand_ff, operand_in;
   logic [32:0]          sum_ff, sum_in;
   logic                 neg_ff, neg_in;
   logic                 oor_ff, oor_in;
   logic [BCD_WIDTH-1:0] shreg_ff, shreg_in;
   logic [7:0]           dp_ff, dp_in;
   logic [2:0]           idx_ff, idx_in;
   logic [2:0]           ul_ff, ul_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   command_type          kind_ff, kind_in;
   logic [2:0]           pos_ff, pos_in;
   logic [3:0]           val_ff, val_in;
   logic                 point_ff, point_in;
   logic                 last_ff, last_in;

   dabble_req_type       dabble_req;
   dabble_rsp_type       dabble_rsp;

   logic                 out_free;
   logic                 accept;
   logic signed [32:0]   add_a, add_b;
   logic                 int_ok, hex_ok;
   logic                 v_neg, v_above;
   logic [31:0]          mag;
   logic [2:0]           nd, ul_base, ll, ul;
   logic [2:0]           idx_next;

   function automatic logic [2:0] map_pos(input logic [17:0] m, input logic [2:0] i);
      logic [2:0] p;
      case (i)
         3'd0:    p = m[2:0];
         3'd1:    p = m[5:3];
         3'd2:    p = m[8:6];
         3'd3:    p = m[11:9];
         3'd4:    p = m[14:12];
         3'd5:    p = m[17:15];
         3'd6:    p = m[2:0];
         default: p = m[5:3];
      endcase
      return p;
   endfunction

   ssnf_dabble u_dabble (
      .clock      (clock),
      .reset      (reset),
      .dabble_req (dabble_req),
      .dabble_rsp (dabble_rsp)
   );

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         map_ff       <= MAP_RESET;
         int_upper_ff <= INT_UPPER_RESET;
         int_lower_ff <= INT_LOWER_RESET;
         hex_upper_ff <= HEX_UPPER_RESET;
         hex_lower_ff <= HEX_LOWER_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_DIGIT_MAP: map_ff       <= csr_write_data[17:0];
            CSR_INT_UPPER: int_upper_ff <= csr_write_data;
            CSR_INT_LOWER: int_lower_ff <= csr_write_data;
            CSR_HEX_UPPER: hex_upper_ff <= csr_write_data;
            CSR_HEX_LOWER: hex_lower_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && !reset;
   assign accept    = req_valid && req_ready;
   assign idx_next  = idx_ff + 3'd1;

   // step adder and limit compare
   always_comb begin
      if (mode_ff == MODE_INT) begin
         add_a = {stored_int_ff[31], stored_int_ff};
         add_b = {operand_ff[31], operand_ff};
      end else begin
         add_a = {1'b0, stored_hex_ff};
         add_b = {1'b0, operand_ff};
      end
      int_ok = ($signed(sum_ff) <= $signed({int_upper_ff[31], int_upper_ff}))
            && ($signed(sum_ff) >= $signed({int_lower_ff[31], int_lower_ff}));
      hex_ok = (sum_ff[31:0] <= hex_upper_ff) && (sum_ff[31:0] >= hex_lower_ff);
   end

   // sign, range and magnitude of the stored integer
   always_comb begin
      v_neg   = stored_int_ff[31] && ($signed(stored_int_ff) >= INT_MIN_SHOWN);
      v_above = !stored_int_ff[31] && ($signed(stored_int_ff) > INT_MAX_SHOWN);
      mag     = v_neg ? (32'd0 - stored_int_ff) : stored_int_ff;
   end

   // digit count and logical span
   always_comb begin
      nd = 3'd1;
      for (int k = 1; k < DIGIT_COUNT; k++) begin
         if (dabble_rsp.bcd[4*k +: 4] != 4'd0) begin
            nd = 3'(k + 1);
         end
      end
      ul_base = neg_ff ? 3'(DIGIT_COUNT - 1) : 3'(DIGIT_COUNT);
      if (stored_align_ff) begin
         ll = 3'd0;
         ul = stored_fill_ff ? ul_base : nd;
      end else begin
         ll = ul_base - nd;
         ul = ul_base;
      end
   end

   always_comb begin
      state_in        = state_ff;
      stored_int_in   = stored_int_ff;
      stored_hex_in   = stored_hex_ff;
      stored_point_in = stored_point_ff;
      stored_align_in = stored_align_ff;
      stored_fill_in  = stored_fill_ff;
      mode_in         = mode_ff;
      op_in           = op_ff;
      operand_in      = operand_ff;
      sum_in          = sum_ff;
      neg_in          = neg_ff;
      oor_in          = oor_ff;
      shreg_in        = shreg_ff;
      dp_in           = dp_ff;
      idx_in          = idx_ff;
      ul_in           = ul_ff;
      dabble_req      = '0;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      kind_in         = kind_ff;
      pos_in          = pos_ff;
      val_in          = val_ff;
      point_in        = point_ff;
      last_in         = last_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in      = opcode_type'(req_opcode);
               operand_in = req_operand;
               case (req_opcode)
                  OP_WRITE_INT: begin
                     stored_int_in   = req_operand;
                     stored_point_in = req_point_mask;
                     stored_align_in = req_align_right;
                     stored_fill_in  = req_zero_fill;
                     mode_in         = MODE_INT;
                     state_in        = S_INT_PREP;
                  end
                  OP_WRITE_HEX: begin
                     stored_hex_in = req_operand;
                     mode_in       = MODE_HEX;
                     shreg_in      = req_operand[BCD_WIDTH-1:0];
                     dp_in         = '0;
                     idx_in        = '0;
                     ul_in         = 3'(DIGIT_COUNT);
                     neg_in        = 1'b0;
                     oor_in        = 1'b0;
                     state_in      = S_CLEAR;
                  end
                  default: begin
                     if (mode_ff != MODE_NONE) begin
                        state_in = S_STEP;
                     end
                  end
               endcase
            end
         end
         S_STEP: begin
            sum_in   = (op_ff == OP_INCREMENT) ? 33'(add_a + add_b) : 33'(add_a - add_b);
            state_in = S_CHECK;
         end
         S_CHECK: begin
            state_in = S_IDLE;
            if (mode_ff == MODE_INT && int_ok) begin
               stored_int_in = sum_ff[31:0];
               state_in      = S_INT_PREP;
            end else if (mode_ff == MODE_HEX && hex_ok) begin
               stored_hex_in = sum_ff[31:0];
               shreg_in      = sum_ff[BCD_WIDTH-1:0];
               dp_in         = '0;
               idx_in        = '0;
               ul_in         = 3'(DIGIT_COUNT);
               neg_in        = 1'b0;
               oor_in        = 1'b0;
               state_in      = S_CLEAR;
            end
         end
         S_INT_PREP: begin
            neg_in           = v_neg;
            oor_in           = (stored_int_ff[31] && !v_neg) || v_above;
            dp_in            = stored_point_ff;
            dabble_req.start = !((stored_int_ff[31] && !v_neg) || v_above);
            dabble_req.value = mag[BIN_WIDTH-1:0];
            state_in         = dabble_req.start ? S_CONV : S_CLEAR;
         end
         S_CONV: begin
            if (dabble_rsp.done) begin
               shreg_in = dabble_rsp.bcd;
               idx_in   = ll;
               ul_in    = ul;
               state_in = S_CLEAR;
            end
         end
         S_CLEAR: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               kind_in      = CMD_CLEAR;
               pos_in       = '0;
               val_in       = '0;
               point_in     = 1'b0;
               last_in      = oor_ff;
               state_in     = oor_ff ? S_IDLE : S_DIGIT;
            end
         end
         S_DIGIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               kind_in      = CMD_DIGIT;
               pos_in       = map_pos(map_ff, idx_ff);
               val_in       = shreg_ff[3:0];
               point_in     = dp_ff[0];
               last_in      = (idx_next == ul_ff) && !neg_ff;
               shreg_in     = {4'd0, shreg_ff[BCD_WIDTH-1:4]};
               dp_in        = {1'b0, dp_ff[7:1]};
               idx_in       = idx_next;
               if (idx_next == ul_ff) begin
                  state_in = neg_ff ? S_MINUS : S_IDLE;
               end
            end
         end
         S_MINUS: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               kind_in      = CMD_MINUS;
               pos_in       = map_pos(map_ff, ul_ff);
               val_in       = '0;
               point_in     = dp_ff[0];
               last_in      = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         rsp_valid_ff    <= 1'b0;
         mode_ff         <= MODE_NONE;
         stored_int_ff   <= '0;
         stored_hex_ff   <= '0;
         stored_point_ff <= '0;
         stored_align_ff <= 1'b0;
         stored_fill_ff  <= 1'b0;
      end else begin
         state_ff        <= state_in;
         rsp_valid_ff    <= rsp_valid_in;
         mode_ff         <= mode_in;
         stored_int_ff   <= stored_int_in;
         stored_hex_ff   <= stored_hex_in;
         stored_point_ff <= stored_point_in;
         stored_align_ff <= stored_align_in;
         stored_fill_ff  <= stored_fill_in;
      end
      op_ff      <= op_in;
      operand_ff <= operand_in;
      sum_ff     <= sum_in;
      neg_ff     <= neg_in;
      oor_ff     <= oor_in;
      shreg_ff   <= shreg_in;
      dp_ff      <= dp_in;
      idx_ff     <= idx_in;
      ul_ff      <= ul_in;
      kind_ff    <= kind_in;
      pos_ff     <= pos_in;
      val_ff     <= val_in;
      point_ff   <= point_in;
      last_ff    <= last_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_command_kind   = kind_ff;
   assign rsp_digit_position = pos_ff;
   assign rsp_digit_value    = val_ff;
   assign rsp_point_on       = point_ff;
   assign rsp_last_command   = last_ff;

   a_write_int_renders: assert property (@(posedge clock) disable iff (reset)
      (accept && req_opcode == OP_WRITE_INT) |=> (state_ff == S_INT_PREP && mode_ff == MODE_INT))
      else $error("write integer did not start rendering");

   a_digit_in_span: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIGIT) |-> (idx_ff < ul_ff))
      else $error("digit index beyond its span");

   a_minus_only_negative: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MINUS) |-> (neg_ff && stored_int_ff[31] && mode_ff == MODE_INT))
      else $error("minus sign for a value that is not negative");

endmodule

>>> design/ssnf_dabble.sv
// Bit-serial binary to BCD converter, one bit per cycle.
module ssnf_dabble (
   input  logic                    clock,
   input  logic                    reset,
   input  ssnf_pkg::dabble_req_type dabble_req,
   output ssnf_pkg::dabble_rsp_type dabble_rsp
);
   import ssnf_pkg::*;

   logic [BIN_WIDTH-1:0] bin_ff, bin_in;
   logic [BCD_WIDTH-1:0] bcd_ff, bcd_in;
   logic [CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [BCD_WIDTH-1:0] adj;
   logic                 digits_ok;

   always_comb begin
      digits_ok = 1'b1;
      for (int k = 0; k < DIGIT_COUNT; k++) begin
         if (bcd_ff[4*k +: 4] >= 4'd5) begin
            adj[4*k +: 4] = bcd_ff[4*k +: 4] + 4'd3;
         end else begin
            adj[4*k +: 4] = bcd_ff[4*k +: 4];
         end
         if (bcd_ff[4*k +: 4] > 4'd9) begin
            digits_ok = 1'b0;
         end
      end
   end

   always_comb begin
      bin_in  = bin_ff;
      bcd_in  = bcd_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (dabble_req.start) begin
         bin_in  = dabble_req.value;
         bcd_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         bin_in = {bin_ff[BIN_WIDTH-2:0], 1'b0};
         bcd_in = {adj[BCD_WIDTH-2:0], bin_ff[BIN_WIDTH-1]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_WIDTH'(BIN_WIDTH - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
      cnt_ff <= cnt_in;
   end

   assign dabble_rsp.done = done_ff;
   assign dabble_rsp.bcd  = bcd_ff;

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("conversion done without a running conversion");

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      dabble_req.start |-> !busy_ff)
      else $error("conversion started while busy");

   a_digits_decimal: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> digits_ok)
      else $error("conversion produced a non-decimal digit");

endmodule

>>> tb/display_command_checker.sv
`timescale 1ns / 1ps
// Checker that predicts the formatter's display commands and compares them with the outputs.
module display_command_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [1:0]         req_opcode,
   input  logic signed [31:0] req_operand,
   input  logic [7:0]         req_point_mask,
   input  logic               req_align_right,
   input  logic               req_zero_fill,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic [1:0]         rsp_command_kind,
   input  logic [2:0]         rsp_digit_position,
   input  logic [3:0]         rsp_digit_value,
   input  logic               rsp_point_on,
   input  logic               rsp_last_command,
   input  logic               csr_write_enable,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_write_data,
   output int                 fail_count,
   output int                 pending_count,
   output int                 command_count
);
   import ssnf_pkg::*;

   typedef struct {
      command_type kind;
      logic [2:0]  position;
      logic [3:0]  value;
      logic        point;
      logic        last;
   } display_command_type;

   display_command_type expected_commands[$];

   logic [17:0]        position_map;
   logic signed [31:0] int_upper;
   logic signed [31:0] int_lower;
   logic [31:0]        hex_upper;
   logic [31:0]        hex_lower;

   logic signed [31:0] shown_int;
   logic [31:0]        shown_hex;
   logic [7:0]         shown_points;
   logic               shown_right;
   logic               shown_fill;
   mode_type           shown_mode;

   function automatic logic [2:0] physical_position(int logical);
      return position_map[3 * (logical % DIGIT_COUNT) +: 3];
   endfunction

   function automatic void queue_command(command_type kind, logic [2:0] position,
                                         logic [3:0] value, logic point);
      display_command_type c;
      c.kind     = kind;
      c.position = position;
      c.value    = value;
      c.point    = point;
      c.last     = 1'b0;
      expected_commands.push_back(c);
   endfunction

   function automatic int decimal_width(longint magnitude);
      int n;
      n = 0;
      if (magnitude == 0) return 1;
      while (magnitude > 0) begin
         magnitude = magnitude / 10;
         n++;
      end
      return n;
   endfunction

   function automatic void render_integer();
      longint     magnitude;
      logic [7:0] points;
      logic [3:0] digit;
      int         low_digit;
      int         high_digit;
      logic       negative;
      magnitude  = longint'(shown_int);
      points     = shown_points;
      low_digit  = 0;
      high_digit = DIGIT_COUNT;
      negative   = 1'b0;
      queue_command(CMD_CLEAR, 3'd0, 4'd0, 1'b0);
      if (magnitude < 0 && magnitude >= longint'(INT_MIN_SHOWN)) begin
         high_digit = DIGIT_COUNT - 1;
         magnitude  = -magnitude;
         negative   = 1'b1;
      end else if (magnitude < 0 || magnitude > longint'(INT_MAX_SHOWN)) begin
         return;
      end
      if (shown_right) begin
         if (!shown_fill) high_digit = decimal_width(magnitude);
      end else begin
         low_digit = high_digit - decimal_width(magnitude);
      end
      for (int i = low_digit; i < high_digit; i++) begin
         digit = 4'(magnitude % 10);
         queue_command(CMD_DIGIT, physical_position(i), digit, points[0]);
         magnitude = magnitude / 10;
         points    = points >> 1;
      end
      if (negative) queue_command(CMD_MINUS, physical_position(high_digit), 4'd0, points[0]);
   endfunction

   function automatic void render_hex();
      queue_command(CMD_CLEAR, 3'd0, 4'd0, 1'b0);
      for (int i = 0; i < DIGIT_COUNT; i++)
         queue_command(CMD_DIGIT, physical_position(i), shown_hex[4 * i +: 4], 1'b0);
   endfunction

   function automatic void predict_commands(opcode_type op, logic signed [31:0] operand,
                                            logic [7:0] mask, logic right, logic fill);
      int          queued_before;
      longint      stepped;
      logic [31:0] wrapped;
      queued_before = expected_commands.size();
      case (op)
         OP_WRITE_INT: begin
            shown_int    = operand;
            shown_points = mask;
            shown_right  = right;
            shown_fill   = fill;
            shown_mode   = MODE_INT;
            render_integer();
         end
         OP_WRITE_HEX: begin
            shown_hex  = operand;
            shown_mode = MODE_HEX;
            render_hex();
         end
         default: begin
            if (shown_mode == MODE_INT) begin
               stepped = (op == OP_INCREMENT) ? longint'(shown_int) + longint'(operand)
                                              : longint'(shown_int) - longint'(operand);
               if (stepped <= longint'(int_upper) && stepped >= longint'(int_lower)) begin
                  shown_int = stepped[31:0];
                  render_integer();
               end
            end else if (shown_mode == MODE_HEX) begin
               wrapped = (op == OP_INCREMENT) ? shown_hex + operand : shown_hex - operand;
               if (wrapped <= hex_upper && wrapped >= hex_lower) begin
                  shown_hex = wrapped;
                  render_hex();
               end
            end
         end
      endcase
      if (expected_commands.size() > queued_before)
         expected_commands[expected_commands.size() - 1].last = 1'b1;
   endfunction

   function automatic void compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0d, got %0d", field, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin : monitor
      display_command_type want;
      if (reset) begin
         position_map  = MAP_RESET;
         int_upper     = INT_UPPER_RESET;
         int_lower     = INT_LOWER_RESET;
         hex_upper     = HEX_UPPER_RESET;
         hex_lower     = HEX_LOWER_RESET;
         shown_int     = '0;
         shown_hex     = '0;
         shown_points  = '0;
         shown_right   = 1'b0;
         shown_fill    = 1'b0;
         shown_mode    = MODE_NONE;
         fail_count    = 0;
         command_count = 0;
         expected_commands.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_DIGIT_MAP: position_map = csr_write_data[17:0];
               CSR_INT_UPPER: int_upper    = csr_write_data;
               CSR_INT_LOWER: int_lower    = csr_write_data;
               CSR_HEX_UPPER: hex_upper    = csr_write_data;
               CSR_HEX_LOWER: hex_lower    = csr_write_data;
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            predict_commands(opcode_type'(req_opcode), req_operand, req_point_mask,
                             req_align_right, req_zero_fill);
         if (rsp_valid && rsp_ready) begin
            command_count++;
            if (expected_commands.size() == 0) begin
               $error("display command kind %0d at position %0d with nothing expected",
                      rsp_command_kind, rsp_digit_position);
               fail_count++;
            end else begin
               want = expected_commands.pop_front();
               compare_field("command_kind", 32'(want.kind), 32'(rsp_command_kind));
               compare_field("digit_position", 32'(want.position), 32'(rsp_digit_position));
               compare_field("digit_value", 32'(want.value), 32'(rsp_digit_value));
               compare_field("point_on", 32'(want.point), 32'(rsp_point_on));
               compare_field("last_command", 32'(want.last), 32'(rsp_last_command));
            end
         end
      end
      pending_count = expected_commands.size();
   end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// Top of the formatter testbench: clock, reset, stimulus, register setup and verdict.
module testbench;
   import ssnf_pkg::*;

   localparam int STALL_LIMIT      = 2000;
   localparam int DRAIN_CYCLES     = 40;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int RANDOM_PER_PHASE = 80;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [1:0]         req_opcode;
   logic signed [31:0] req_operand;
   logic [7:0]         req_point_mask;
   logic               req_align_right;
   logic               req_zero_fill;
   logic               rsp_valid;
   logic               rsp_ready;
   logic [1:0]         rsp_command_kind;
   logic [2:0]         rsp_digit_position;
   logic [3:0]         rsp_digit_value;
   logic               rsp_point_on;
   logic               rsp_last_command;
   logic               csr_write_enable;
   logic [2:0]         csr_index;
   logic [31:0]        csr_write_data;

   int   fail_count;
   int   pending_count;
   int   command_count;
   int   requests_sent;
   int   writes_done;
   int   send_calm;
   int   idle_cycles;
   logic long_hold_request;

   seven_segment_number_formatter u_top (.*);

   display_command_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin : receiver
      int stall;
      int calm_left;
      calm_left = 0;
      rsp_ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (long_hold_request) begin
            long_hold_request = 1'b0;
            stall = LONG_HOLD_CYCLES;
         end else if (calm_left > 0) begin
            stall = 0;
            calm_left--;
         end else begin
            stall = $urandom_range(0, 9);
            if ($urandom_range(0, 24) == 0) calm_left = 40;
         end
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   task automatic send_request(opcode_type op, logic signed [31:0] operand,
                               logic [7:0] mask, logic right, logic fill);
      int gap;
      if (send_calm > 0) begin
         gap = 0;
         send_calm--;
      end else begin
         gap = $urandom_range(0, 9);
         if ($urandom_range(0, 24) == 0) send_calm = 30;
      end
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_opcode      <= op;
      req_operand     <= operand;
      req_point_mask  <= mask;
      req_align_right <= right;
      req_zero_fill   <= fill;
      do @(posedge clock); while (!req_ready);
      requests_sent++;
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_count != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(csr_index_type idx, logic [31:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
      writes_done++;
   endtask

   task automatic configure(logic [17:0] map, logic [31:0] int_hi, logic [31:0] int_lo,
                            logic [31:0] hex_hi, logic [31:0] hex_lo);
      write_register(CSR_DIGIT_MAP, {14'd0, map});
      write_register(CSR_INT_UPPER, int_hi);
      write_register(CSR_INT_LOWER, int_lo);
      write_register(CSR_HEX_UPPER, hex_hi);
      write_register(CSR_HEX_LOWER, hex_lo);
   endtask

   task automatic random_request();
      opcode_type         op;
      logic signed [31:0] operand;
      int                 pick;
      pick = $urandom_range(0, 99);
      if (pick < 25)      op = OP_WRITE_INT;
      else if (pick < 40) op = OP_WRITE_HEX;
      else if (pick < 70) op = OP_INCREMENT;
      else                op = OP_DECREMENT;
      case (op)
         OP_WRITE_INT: begin
            case ($urandom_range(0, 9))
               0:       operand = $urandom;
               1:       operand = ($urandom_range(0, 1) ? INT_MAX_SHOWN : INT_MIN_SHOWN)
                                  + $urandom_range(0, 2) - 1;
               2, 3, 4: operand = $urandom_range(0, 400) - 200;
               default: operand = $urandom_range(0, 1099998) - 99999;
            endcase
         end
         OP_WRITE_HEX: begin
            case ($urandom_range(0, 4))
               0:       operand = 32'h00FF_FFF0 + $urandom_range(0, 31);
               1:       operand = $urandom_range(0, 31);
               2:       operand = 32'h0000_0F00 + $urandom_range(0, 256);
               default: operand = $urandom;
            endcase
         end
         default: begin
            case ($urandom_range(0, 19))
               0:       operand = $urandom;
               1, 2:    operand = $urandom_range(0, 2000) - 1000;
               default: operand = $urandom_range(0, 20);
            endcase
         end
      endcase
      send_request(op, operand, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)));
   endtask

   task automatic directed_requests();
      send_request(OP_INCREMENT, 1, 8'h00, 1'b0, 1'b0);
      send_request(OP_DECREMENT, 32'h8000_0000, 8'hFF, 1'b1, 1'b1);
      send_request(OP_WRITE_INT, 0, 8'h00, 1'b1, 1'b0);
      send_request(OP_WRITE_INT, 0, 8'h01, 1'b0, 1'b0);
      send_request(OP_WRITE_INT, INT_MAX_SHOWN, 8'hFF, 1'b1, 1'b1);
      send_request(OP_WRITE_INT, INT_MAX_SHOWN + 1, 8'hFF, 1'b1, 1'b0);
      send_request(OP_WRITE_INT, INT_MIN_SHOWN, 8'hAA, 1'b0, 1'b0);
      send_request(OP_WRITE_INT, INT_MIN_SHOWN - 1, 8'h55, 1'b1, 1'b1);
      send_request(OP_WRITE_INT, -5, 8'h03, 1'b1, 1'b0);
      send_request(OP_WRITE_INT, -5, 8'h3F, 1'b1, 1'b1);
      send_request(OP_WRITE_INT, 32'h7FFF_FFFF, 8'h00, 1'b1, 1'b1);
      send_request(OP_WRITE_INT, 32'h8000_0000, 8'h00, 1'b0, 1'b1);
      send_request(OP_WRITE_INT, 42, 8'hC0, 1'b0, 1'b1);
      send_request(OP_WRITE_INT, 999998, 8'h00, 1'b1, 1'b0);
      send_request(OP_INCREMENT, 1, 8'h00, 1'b0, 1'b0);
      send_request(OP_INCREMENT, 1, 8'h00, 1'b0, 1'b0);
      send_request(OP_DECREMENT, 32'h8000_0000, 8'h00, 1'b0, 1'b0);
      send_request(OP_WRITE_INT, -99998, 8'h0F, 1'b1, 1'b0);
      send_request(OP_DECREMENT, 1, 8'h00, 1'b0, 1'b0);
      send_request(OP_DECREMENT, 1, 8'h00, 1'b0, 1'b0);
      send_request(OP_INCREMENT, 100, 8'h00, 1'b0, 1'b0);
      send_request(OP_WRITE_HEX, 32'hFFFF_FFFF, 8'hFF, 1'b1, 1'b1);
      send_request(OP_INCREMENT, 1, 8'h00, 1'b0, 1'b0);
      send_request(OP_DECREMENT, 1, 8'h00, 1'b0, 1'b0);
      send_request(OP_WRITE_HEX, 32'h00AB_CDEF, 8'h00, 1'b0, 1'b0);
      send_request(OP_DECREMENT, 32'hFFFF_FFFF, 8'h00, 1'b0, 1'b0);
   endtask

   initial begin : stimulus
      reset             <= 1'b1;
      req_valid         <= 1'b0;
      req_opcode        <= OP_WRITE_INT;
      req_operand       <= '0;
      req_point_mask    <= '0;
      req_align_right   <= 1'b0;
      req_zero_fill     <= 1'b0;
      csr_write_enable  <= 1'b0;
      csr_index         <= CSR_DIGIT_MAP;
      csr_write_data    <= '0;
      long_hold_request = 1'b0;
      send_calm         = 0;
      requests_sent     = 0;
      writes_done       = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      directed_requests();
      settle();

      // back up the request side behind a long receiver hold
      long_hold_request = 1'b1;
      repeat (RANDOM_PER_PHASE) random_request();
      settle();

      configure(18'($urandom_range(0, 18'h3FFFF)), 32'h7FFF_FFFF, 32'h8000_0000,
                32'hFFFF_FFFF, 32'h0000_0000);
      repeat (RANDOM_PER_PHASE / 2) random_request();
      settle();
      repeat (RANDOM_PER_PHASE / 2) random_request();
      settle();

      configure(18'h00000, 100, -100, 32'h0000_1000, 32'h0000_0F00);
      repeat (RANDOM_PER_PHASE) random_request();
      settle();

      // crossed limits: refuse every step
      configure(18'h3FFFF, -5, 5, 5, 10);
      repeat (RANDOM_PER_PHASE) random_request();
      settle();

      configure(18'o012345, INT_UPPER_RESET, INT_LOWER_RESET, HEX_UPPER_RESET,
                HEX_LOWER_RESET);
      repeat (RANDOM_PER_PHASE / 4) random_request();
      settle();

      $display("Covered %0d requests (directed and random) over five limit and map settings",
               requests_sent);
      $display("with %0d register writes; %0d display commands compared, %0d outstanding",
               writes_done, command_count, pending_count);
      if (fail_count == 0 && pending_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
